### design/chip8_cpu_core_defines.svh
// Assertion macros for the CHIP-8 core.
`ifndef CHIP8_CPU_CORE_DEFINES_SVH
`define CHIP8_CPU_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define C8_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define C8_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define C8_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define C8_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### design/c8_pkg.sv
package c8_pkg;

  localparam logic [11:0] PROG_START = 12'h200;
  localparam int SCREEN_H = 32;

  localparam logic [2:0] CMD_EXEC  = 3'd0;
  localparam logic [2:0] CMD_TICK  = 3'd1;
  localparam logic [2:0] CMD_KEY   = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADOP = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_STACK = 2'd3;

  localparam logic [3:0] OPC_SYS    = 4'h0;
  localparam logic [3:0] OPC_JP     = 4'h1;
  localparam logic [3:0] OPC_CALL   = 4'h2;
  localparam logic [3:0] OPC_SE_I   = 4'h3;
  localparam logic [3:0] OPC_SNE_I  = 4'h4;
  localparam logic [3:0] OPC_SE_R   = 4'h5;
  localparam logic [3:0] OPC_LD_I   = 4'h6;
  localparam logic [3:0] OPC_ADD_I  = 4'h7;
  localparam logic [3:0] OPC_ALU    = 4'h8;
  localparam logic [3:0] OPC_SNE_R  = 4'h9;
  localparam logic [3:0] OPC_LD_IDX = 4'hA;
  localparam logic [3:0] OPC_JP_V0  = 4'hB;
  localparam logic [3:0] OPC_RND    = 4'hC;
  localparam logic [3:0] OPC_DRW    = 4'hD;
  localparam logic [3:0] OPC_SKP    = 4'hE;
  localparam logic [3:0] OPC_MISC   = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] AL_MOV  = 4'h0;
  localparam logic [3:0] AL_OR   = 4'h1;
  localparam logic [3:0] AL_AND  = 4'h2;
  localparam logic [3:0] AL_XOR  = 4'h3;
  localparam logic [3:0] AL_ADD  = 4'h4;
  localparam logic [3:0] AL_SUB  = 4'h5;
  localparam logic [3:0] AL_SHR  = 4'h6;
  localparam logic [3:0] AL_SUBN = 4'h7;
  localparam logic [3:0] AL_SHL  = 4'hE;

  localparam logic [7:0] SK_DOWN   = 8'h9E;
  localparam logic [7:0] SK_UP     = 8'hA1;
  localparam logic [7:0] FN_LD_DT  = 8'h07;
  localparam logic [7:0] FN_WAIT   = 8'h0A;
  localparam logic [7:0] FN_SET_DT = 8'h15;
  localparam logic [7:0] FN_SET_ST = 8'h18;
  localparam logic [7:0] FN_ADD_I  = 8'h1E;
  localparam logic [7:0] FN_FONT   = 8'h29;
  localparam logic [7:0] FN_BCD    = 8'h33;
  localparam logic [7:0] FN_STORE  = 8'h55;
  localparam logic [7:0] FN_LOAD   = 8'h65;

  localparam logic [1:0] DIG_HUND = 2'd0;
  localparam logic [1:0] DIG_TENS = 2'd1;
  localparam logic [1:0] DIG_ONES = 2'd2;

  localparam logic [7:0] FONT [80] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CMD, S_F0, S_F1, S_F2, S_RD, S_EX, S_WBF,
    S_DRA, S_DRB, S_DRF, S_BCD, S_S55R, S_S55W, S_L65R, S_L65W, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  key_index;
    logic        key_down;
    logic [11:0] mem_addr;
    logic [7:0]  mem_data;
    logic [7:0]  random_byte;
    logic [4:0]  row_select;
  } req_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic        waiting_for_key;
    logic        sound_on;
    logic [1:0]  status;
    logic [63:0] display_row;
    logic        screen_changed;
  } rsp_t;

  typedef struct packed {
    logic        we;
    logic [11:0] addr;
    logic [7:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic       we;
    logic [3:0] addr;
    logic [7:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       eq;
  } alu_rsp_t;

  function automatic logic [7:0] font_byte(input logic [11:0] a);
    logic [7:0] v;
    v = 8'h00;
    if (a < 12'd80) begin
      v = FONT[a[6:0]];
    end
    return v;
  endfunction

  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [7:0]  rem;
    logic [1:0]  hund;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    logic [7:0]  d;
    if (v >= 8'd200) begin
      hund = 2'd2;
      rem = v - 8'd200;
    end else if (v >= 8'd100) begin
      hund = 2'd1;
      rem = v - 8'd100;
    end else begin
      hund = 2'd0;
      rem = v;
    end
    prod = 15'(rem[6:0]) * 15'd205;
    tens = prod[14:11];
    ones = rem - 8'(tens) * 8'd10;
    unique case (sel)
      DIG_HUND: d = {6'd0, hund};
      DIG_TENS: d = {4'd0, tens};
      DIG_ONES: d = ones;
      default:  d = 8'd0;
    endcase
    return d;
  endfunction

endpackage

### design/c8_alu.sv
module c8_alu
  import c8_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [8:0] sum;

  assign sum = {1'b0, req.a} + {1'b0, req.b};

  always_comb begin
    rsp.eq = (req.a == req.b);
    rsp.flag = 1'b0;
    rsp.res = req.b;
    unique case (req.op)
      AL_MOV: rsp.res = req.b;
      AL_OR:  rsp.res = req.a | req.b;
      AL_AND: rsp.res = req.a & req.b;
      AL_XOR: rsp.res = req.a ^ req.b;
      AL_ADD: begin
        rsp.res = sum[7:0];
        rsp.flag = sum[8];
      end
      AL_SUB: begin
        rsp.res = req.a - req.b;
        rsp.flag = (req.a >= req.b);
      end
      AL_SHR: begin
        rsp.res = {1'b0, req.a[7:1]};
        rsp.flag = req.a[0];
      end
      AL_SUBN: begin
        rsp.res = req.b - req.a;
        rsp.flag = (req.b >= req.a);
      end
      AL_SHL: begin
        rsp.res = {req.a[6:0], 1'b0};
        rsp.flag = req.a[7];
      end
      default: rsp.res = req.b;
    endcase
  end

endmodule

### design/c8_regs.sv
module c8_regs
  import c8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  rf_wr_t     wr,
  input  logic [3:0] ra,
  input  logic [3:0] rb,
  output logic [7:0] rd_a,
  output logic [7:0] rd_b
);

  logic [7:0]  regs [16];
  logic [15:0] valid;
  logic [7:0]  raw_a;
  logic [7:0]  raw_b;
  logic        val_a;
  logic        val_b;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      regs[wr.addr] <= wr.data;
    end
    raw_a <= regs[ra];
    raw_b <= regs[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      val_a <= 1'b0;
      val_b <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[wr.addr] <= 1'b1;
      end
      val_a <= valid[ra];
      val_b <= valid[rb];
    end
  end

  assign rd_a = val_a ? raw_a : 8'd0;
  assign rd_b = val_b ? raw_b : 8'd0;

endmodule

### design/c8_mem.sv
module c8_mem
  import c8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mem_wr_t     wr,
  input  logic [11:0] raddr,
  output logic [7:0]  rdata,
  output logic        ready
);

  logic [7:0]  mem [4096];
  logic        clearing;
  logic [11:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 12'd1;
      if (clr_addr == 12'hFFF) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= font_byte(clr_addr);
    end else if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

  assign ready = !clearing;

endmodule

### design/chip8_cpu_core.sv
// Commands other than execute go from S_CMD to S_DONE, which raises done; busy drops back in S_IDLE.
// Execute runs two registered memory fetches (S_F0 to S_F2), a register read (S_RD) and one step (S_EX).
// 8XY4 to 8XYE add S_WBF for the flag write; DXYN adds S_DRA and S_DRB per sprite row plus S_DRF for the flag.
// FX55 and FX65 add a read and a write state per register, FX33 writes one digit per pass through S_BCD.
// After rst the memory is loaded with the font and zeroed, one byte a cycle, over all 4096 addresses.
// Results appear for one cycle with done; the receiver cannot stall.
`include "chip8_cpu_core_defines.svh"

module chip8_cpu_core
  import c8_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  output logic        busy,
  output logic        done,
  output rsp_t        result,
  input  logic        cfg_we,
  input  logic [11:0] cfg_data
);

  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int SDW = $clog2(STACK_DEPTH + 1);

  state_t state, state_next;

  logic [11:0] plen;
  logic [11:0] pc;
  logic [15:0] ireg;
  logic [7:0]  delay;
  logic [7:0]  sound;
  logic [15:0] keys;
  logic        wait_flag;
  logic [3:0]  wait_target;
  logic        ended;
  logic [11:0] stack [STACK_DEPTH];
  logic [SDW-1:0] depth;
  logic [SDW-1:0] depth_m1;
  logic [63:0] frame [SCREEN_H];

  req_t        req_q;
  logic [15:0] op_q;
  logic [3:0]  cnt;
  logic        flag_q;
  logic [1:0]  status_q;
  logic        drew_q;

  logic [3:0]  opc, x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [11:0] pc_plus2, pc_plus4;
  logic        limit_hit;
  logic        n_ok;
  logic [11:0] i_cnt;
  logic [15:0] i_adv;
  logic [4:0]  draw_row;
  logic [4:0]  frame_sel;
  logic [63:0] frame_rd;
  logic [127:0] dbl;
  logic [127:0] rot;
  logic [63:0] mask;

  logic [11:0] mem_raddr;
  logic [7:0]  mem_rdata;
  logic        mem_ready;
  mem_wr_t     mem_wr;
  logic [3:0]  rf_ra, rf_rb;
  logic [7:0]  rd_a, rd_b;
  rf_wr_t      rf_wr;
  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;

  c8_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .ready (mem_ready)
  );

  c8_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .wr   (rf_wr),
    .ra   (rf_ra),
    .rb   (rf_rb),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  c8_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign opc = op_q[15:12];
  assign x = op_q[11:8];
  assign y = op_q[7:4];
  assign n = op_q[3:0];
  assign nn = op_q[7:0];
  assign nnn = op_q[11:0];
  assign pc_plus2 = pc + 12'd2;
  assign pc_plus4 = pc + 12'd4;
  assign limit_hit = {1'b0, pc} >= (13'(PROG_START) + {1'b0, plen} + 13'd1);
  assign n_ok = (n <= AL_SUBN) || (n == AL_SHL);
  assign i_cnt = ireg[11:0] + {8'd0, cnt};
  assign i_adv = ireg + {12'd0, x} + 16'd1;
  assign depth_m1 = depth - SDW'(1);
  assign draw_row = rd_b[4:0] + {1'b0, cnt};
  assign frame_sel = (state == S_DONE) ? req_q.row_select : draw_row;
  assign frame_rd = frame[frame_sel];
  assign dbl = {mem_rdata, 56'd0, mem_rdata, 56'd0};
  assign rot = dbl >> rd_a[5:0];
  assign mask = rot[63:0];

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign result.program_counter = pc;
  assign result.waiting_for_key = wait_flag;
  assign result.sound_on = (sound != 8'd0);
  assign result.status = status_q;
  assign result.display_row = frame_rd;
  assign result.screen_changed = drew_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_raddr = pc;
    mem_wr = '0;
    rf_ra = x;
    rf_rb = (opc == OPC_JP_V0) ? 4'd0 : y;
    rf_wr = '0;
    alu_req.op = AL_MOV;
    alu_req.a = rd_a;
    alu_req.b = nn;
    unique case (state)
      S_CLEAR: begin
        if (mem_ready) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_CMD;
        end
      end
      S_CMD: begin
        state_next = S_DONE;
        if (req_q.cmd == CMD_EXEC && !wait_flag && !ended && !limit_hit) begin
          state_next = S_F0;
        end
        if (req_q.cmd == CMD_KEY && req_q.key_down && wait_flag) begin
          rf_wr = '{we: 1'b1, addr: wait_target, data: {4'd0, req_q.key_index}};
        end
        if (req_q.cmd == CMD_WRITE) begin
          mem_wr = '{we: 1'b1, addr: req_q.mem_addr, data: req_q.mem_data};
        end
      end
      S_F0: state_next = S_F1;
      S_F1: begin
        mem_raddr = pc + 12'd1;
        state_next = S_F2;
      end
      S_F2: state_next = S_RD;
      S_RD: state_next = S_EX;
      S_EX: begin
        state_next = S_DONE;
        unique case (opc)
          OPC_SE_R, OPC_SNE_R: alu_req.b = rd_b;
          OPC_ADD_I: begin
            alu_req.op = AL_ADD;
            rf_wr = '{we: 1'b1, addr: x, data: alu_rsp.res};
          end
          OPC_LD_I: rf_wr = '{we: 1'b1, addr: x, data: nn};
          OPC_RND: rf_wr = '{we: 1'b1, addr: x, data: req_q.random_byte & nn};
          OPC_ALU: begin
            alu_req.op = n;
            alu_req.b = rd_b;
            if (n_ok) begin
              rf_wr = '{we: 1'b1, addr: x, data: alu_rsp.res};
              if (n >= AL_ADD) begin
                state_next = S_WBF;
              end
            end
          end
          OPC_DRW: state_next = (n == 4'd0) ? S_DRF : S_DRA;
          OPC_MISC: begin
            if (nn == FN_LD_DT) begin
              rf_wr = '{we: 1'b1, addr: x, data: delay};
            end
            if (nn == FN_BCD) begin
              state_next = S_BCD;
            end
            if (nn == FN_STORE) begin
              state_next = S_S55R;
            end
            if (nn == FN_LOAD) begin
              state_next = S_L65R;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_WBF: begin
        rf_wr = '{we: 1'b1, addr: 4'hF, data: {7'd0, flag_q}};
        state_next = S_DONE;
      end
      S_DRA: begin
        mem_raddr = i_cnt;
        state_next = S_DRB;
      end
      S_DRB: state_next = (cnt == n - 4'd1) ? S_DRF : S_DRA;
      S_DRF: begin
        rf_wr = '{we: 1'b1, addr: 4'hF, data: {7'd0, flag_q}};
        state_next = S_DONE;
      end
      S_BCD: begin
        mem_wr = '{we: 1'b1, addr: i_cnt, data: bcd_digit(rd_a, cnt[1:0])};
        if (cnt[1:0] == DIG_ONES) begin
          state_next = S_DONE;
        end
      end
      S_S55R: begin
        rf_ra = cnt;
        state_next = S_S55W;
      end
      S_S55W: begin
        rf_ra = cnt;
        mem_wr = '{we: 1'b1, addr: i_cnt, data: rd_a};
        state_next = (cnt == x) ? S_DONE : S_S55R;
      end
      S_L65R: begin
        mem_raddr = i_cnt;
        state_next = S_L65W;
      end
      S_L65W: begin
        rf_wr = '{we: 1'b1, addr: cnt, data: mem_rdata};
        state_next = (cnt == x) ? S_DONE : S_L65R;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= 12'd3584;
      pc <= PROG_START;
      ireg <= '0;
      delay <= '0;
      sound <= '0;
      keys <= '0;
      wait_flag <= 1'b0;
      wait_target <= '0;
      ended <= 1'b0;
      depth <= '0;
      for (int r = 0; r < SCREEN_H; r++) begin
        frame[r] <= '0;
      end
    end else begin
      if (cfg_we) begin
        plen <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q <= req;
            status_q <= ST_OK;
            drew_q <= 1'b0;
            cnt <= '0;
          end
        end
        S_CMD: begin
          if (req_q.cmd == CMD_TICK) begin
            if (delay != 8'd0) begin
              delay <= delay - 8'd1;
            end
            if (sound != 8'd0) begin
              sound <= sound - 8'd1;
            end
          end
          if (req_q.cmd == CMD_KEY) begin
            keys[req_q.key_index] <= req_q.key_down;
            if (req_q.key_down) begin
              wait_flag <= 1'b0;
            end
          end
          if (req_q.cmd == CMD_EXEC && !wait_flag && (ended || limit_hit)) begin
            ended <= 1'b1;
            status_q <= ST_END;
          end
        end
        S_F1: op_q[15:8] <= mem_rdata;
        S_F2: op_q[7:0] <= mem_rdata;
        S_EX: begin
          pc <= pc_plus2;
          flag_q <= alu_rsp.flag;
          unique case (opc)
            OPC_SYS: begin
              if (op_q == OP_CLS) begin
                for (int r = 0; r < SCREEN_H; r++) begin
                  frame[r] <= '0;
                end
                drew_q <= 1'b1;
              end else if (op_q == OP_RET) begin
                if (depth == '0) begin
                  status_q <= ST_STACK;
                end else begin
                  depth <= depth_m1;
                  pc <= stack[depth_m1[SIW-1:0]];
                end
              end else begin
                status_q <= ST_BADOP;
              end
            end
            OPC_JP: pc <= nnn;
            OPC_CALL: begin
              if (depth >= SDW'(STACK_DEPTH)) begin
                status_q <= ST_STACK;
              end else begin
                stack[depth[SIW-1:0]] <= pc_plus2;
                depth <= depth + SDW'(1);
                pc <= nnn;
              end
            end
            OPC_SE_I, OPC_SE_R: begin
              if (alu_rsp.eq) begin
                pc <= pc_plus4;
              end
            end
            OPC_SNE_I, OPC_SNE_R: begin
              if (!alu_rsp.eq) begin
                pc <= pc_plus4;
              end
            end
            OPC_ALU: begin
              if (!n_ok) begin
                status_q <= ST_BADOP;
              end
            end
            OPC_LD_IDX: ireg <= {4'd0, nnn};
            OPC_JP_V0: pc <= nnn + {4'd0, rd_b};
            OPC_DRW: begin
              flag_q <= 1'b0;
              drew_q <= 1'b1;
            end
            OPC_SKP: begin
              if (nn == SK_DOWN) begin
                if (keys[rd_a[3:0]]) begin
                  pc <= pc_plus4;
                end
              end else if (nn == SK_UP) begin
                if (!keys[rd_a[3:0]]) begin
                  pc <= pc_plus4;
                end
              end else begin
                status_q <= ST_BADOP;
              end
            end
            OPC_MISC: begin
              unique case (nn)
                FN_LD_DT: ;
                FN_WAIT: begin
                  wait_flag <= 1'b1;
                  wait_target <= x;
                end
                FN_SET_DT: delay <= rd_a;
                FN_SET_ST: sound <= rd_a;
                FN_ADD_I: ireg <= ireg + {8'd0, rd_a};
                FN_FONT: ireg <= {6'd0, rd_a, 2'd0} + {8'd0, rd_a};
                FN_BCD, FN_STORE, FN_LOAD: cnt <= '0;
                default: status_q <= ST_BADOP;
              endcase
            end
            default: ;
          endcase
        end
        S_DRB: begin
          frame[draw_row] <= frame_rd ^ mask;
          if ((frame_rd & mask) != 64'd0) begin
            flag_q <= 1'b1;
          end
          cnt <= cnt + 4'd1;
        end
        S_BCD: cnt <= cnt + 4'd1;
        S_S55W, S_L65W: begin
          cnt <= cnt + 4'd1;
          if (cnt == x) begin
            ireg <= i_adv;
          end
        end
        default: ;
      endcase
    end
  end

  `C8_ASSERT_IMP(a_done_busy, clk, rst, done, busy, "done raised while idle")
  `C8_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "request not taken")
  `C8_ASSERT_NXT(a_done_single, clk, rst, done, !done && !busy, "done longer than one cycle")
  `C8_ASSERT_IMP(a_depth, clk, rst, 1'b1, depth <= SDW'(STACK_DEPTH), "stack depth beyond size")

endmodule
